// ----- hw/rtl/ppp_pkg.sv -----
// Package: shared constants and types for the pinhole point projection core.
`timescale 1ns / 1ps
package ppp_pkg;
    localparam int DATA_W   = 32;
    localparam int COEF_W   = 32;
    localparam int NUM_REGS = 6;
    localparam int APB_AW   = 6;
    localparam int APB_DW   = 64;
    localparam int QUO_BITS = 33;

    localparam logic [2:0] REG_R0_C0C1 = 3'd0;
    localparam logic [2:0] REG_R0_C2C3 = 3'd1;
    localparam logic [2:0] REG_R1_C0C1 = 3'd2;
    localparam logic [2:0] REG_R1_C2C3 = 3'd3;
    localparam logic [2:0] REG_R2_C0C1 = 3'd4;
    localparam logic [2:0] REG_R2_C2C3 = 3'd5;

    typedef struct packed {
        logic [DATA_W-1:0] col_index;
        logic [DATA_W-1:0] row_index;
        logic              depth_zero;
        logic              saturated;
    } t_result;
endpackage

// ----- hw/rtl/ppp_if.sv -----
// Interfaces: point input channel and projection result channel.
`timescale 1ns / 1ps
interface ppp_pt_if import ppp_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] pt_x;
    logic signed [DATA_W-1:0] pt_y;
    logic signed [DATA_W-1:0] pt_z;
    modport source (output valid, output pt_x, output pt_y, output pt_z, input ready);
    modport sink (input valid, input pt_x, input pt_y, input pt_z, output ready);
endinterface

interface ppp_res_if import ppp_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] col_index;
    logic signed [DATA_W-1:0] row_index;
    logic                     depth_zero;
    logic                     saturated;
    modport source (output valid, output col_index, output row_index, output depth_zero,
                    output saturated, input ready);
    modport sink (input valid, input col_index, input row_index, input depth_zero,
                  input saturated, output ready);
endinterface

// ----- hw/rtl/pinhole_point_projection_core.sv -----
// Pipeline of 39 register stages from an accepted point transaction to result valid:
//   multiply, two add stages, abs, range check,
//   33 restoring-division steps (one per stage, two lanes), then the output register.
// Throughput: one point per cycle while results are taken.
// A two-entry output buffer keeps input ready high while one result waits.
// Reset (synchronous, active low) clears valids and all coefficients to zero.
`timescale 1ns / 1ps
module pinhole_point_projection_core import ppp_pkg::*; #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ppp_pt_if.sink            i_pt,
    ppp_res_if.source         o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);
    localparam int PW   = COEF_W + COORD_WIDTH;
    localparam int C3W  = COEF_W + FRAC_BITS;
    localparam int SW   = (PW > C3W) ? PW : C3W;
    localparam int HW   = SW + 2;
    localparam int NW   = HW + FRAC_BITS;
    localparam int QB   = QUO_BITS;
    localparam int NSTG = 5 + QB;

    // configuration registers
    logic [APB_DW-1:0] r_coef [NUM_REGS];
    logic [2:0]        w_idx;

    assign w_idx  = paddr[5:3];
    assign pready = 1'b1;
    assign prdata = (w_idx < 3'(NUM_REGS)) ? r_coef[w_idx] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) r_coef[i] <= '0;
        end else if (psel && penable && pwrite && (w_idx < 3'(NUM_REGS))) begin
            r_coef[w_idx] <= pwdata;
        end
    end

    logic signed [COEF_W-1:0] w_cf [3][4];
    always_comb begin
        w_cf[0][0] = r_coef[REG_R0_C0C1][31:0];
        w_cf[0][1] = r_coef[REG_R0_C0C1][63:32];
        w_cf[0][2] = r_coef[REG_R0_C2C3][31:0];
        w_cf[0][3] = r_coef[REG_R0_C2C3][63:32];
        w_cf[1][0] = r_coef[REG_R1_C0C1][31:0];
        w_cf[1][1] = r_coef[REG_R1_C0C1][63:32];
        w_cf[1][2] = r_coef[REG_R1_C2C3][31:0];
        w_cf[1][3] = r_coef[REG_R1_C2C3][63:32];
        w_cf[2][0] = r_coef[REG_R2_C0C1][31:0];
        w_cf[2][1] = r_coef[REG_R2_C0C1][63:32];
        w_cf[2][2] = r_coef[REG_R2_C2C3][31:0];
        w_cf[2][3] = r_coef[REG_R2_C2C3][63:32];
    end

    // pipeline control
    logic            w_en;
    logic            w_take;
    logic [NSTG-1:0] r_v;
    logic            r_out_v;
    logic            r_skid_v;
    t_result         r_out;
    t_result         r_skid;
    t_result         w_new;

    assign w_en       = !r_skid_v;
    assign i_pt.ready = w_en;
    assign w_take     = r_out_v && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NSTG-2:0], i_pt.valid};
        end
    end

    // multiply stage
    logic signed [COORD_WIDTH-1:0] w_x, w_y, w_z;
    logic signed [PW-1:0]          r_p [3][3];
    logic signed [C3W-1:0]         r_c3 [3];

    assign w_x = i_pt.pt_x[COORD_WIDTH-1:0];
    assign w_y = i_pt.pt_y[COORD_WIDTH-1:0];
    assign w_z = i_pt.pt_z[COORD_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int r = 0; r < 3; r++) begin
                r_p[r][0] <= w_cf[r][0] * w_x;
                r_p[r][1] <= w_cf[r][1] * w_y;
                r_p[r][2] <= w_cf[r][2] * w_z;
                r_c3[r]   <= {w_cf[r][3], {FRAC_BITS{1'b0}}};
            end
        end
    end

    // sums
    logic signed [HW-1:0] r_a [3];
    logic signed [HW-1:0] r_b [3];
    logic signed [HW-1:0] r_h [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int r = 0; r < 3; r++) begin
                r_a[r] <= HW'(r_p[r][0]) + HW'(r_p[r][1]);
                r_b[r] <= HW'(r_p[r][2]) + HW'(r_c3[r]);
                r_h[r] <= r_a[r] + r_b[r];
            end
        end
    end

    // magnitudes and signs
    logic [HW-1:0] r_mag [2];
    logic [HW-1:0] r_dmag;
    logic          r_neg4 [2];
    logic          r_dz4;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < 2; l++) begin
                r_mag[l]  <= r_h[l][HW-1] ? HW'(-r_h[l]) : HW'(r_h[l]);
                r_neg4[l] <= r_h[l][HW-1] ^ r_h[2][HW-1];
            end
            r_dmag <= r_h[2][HW-1] ? HW'(-r_h[2]) : HW'(r_h[2]);
            r_dz4  <= (r_h[2] == '0);
        end
    end

    // division steps; index 0 holds the range check result
    logic [HW-1:0] r_rem [QB+1][2];
    logic [QB-1:0] r_lo  [QB+1][2];
    logic [QB-1:0] r_q   [QB+1][2];
    logic          r_ovf [QB+1][2];
    logic          r_neg [QB+1][2];
    logic [HW-1:0] r_d   [QB+1];
    logic          r_dz  [QB+1];

    logic [NW-1:0] w_num [2];
    always_comb begin
        for (int l = 0; l < 2; l++) w_num[l] = {r_mag[l], {FRAC_BITS{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < 2; l++) begin
                r_ovf[0][l] <= NW'(w_num[l][NW-1:QB]) >= NW'(r_dmag);
                r_rem[0][l] <= HW'(w_num[l][NW-1:QB]);
                r_lo[0][l]  <= w_num[l][QB-1:0];
                r_q[0][l]   <= '0;
                r_neg[0][l] <= r_neg4[l];
            end
            r_d[0]  <= r_dmag;
            r_dz[0] <= r_dz4;
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_step
        logic [HW:0] w_t  [2];
        logic        w_ge [2];
        always_comb begin
            for (int l = 0; l < 2; l++) begin
                w_t[l]  = {r_rem[k][l], r_lo[k][l][QB-1]};
                w_ge[l] = w_t[l] >= {1'b0, r_d[k]};
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                for (int l = 0; l < 2; l++) begin
                    r_rem[k+1][l] <= w_ge[l] ? HW'(w_t[l] - {1'b0, r_d[k]}) : HW'(w_t[l]);
                    r_lo[k+1][l]  <= {r_lo[k][l][QB-2:0], 1'b0};
                    r_q[k+1][l]   <= {r_q[k][l][QB-2:0], w_ge[l]};
                    r_ovf[k+1][l] <= r_ovf[k][l];
                    r_neg[k+1][l] <= r_neg[k][l];
                end
                r_d[k+1]  <= r_d[k];
                r_dz[k+1] <= r_dz[k];
            end
        end
    end

    // final saturation and sign
    logic [DATA_W-1:0] w_res [2];
    logic              w_sat [2];
    always_comb begin
        logic [QB-1:0]     v_lim;
        logic [DATA_W-1:0] v_mag;
        for (int l = 0; l < 2; l++) begin
            v_lim    = r_neg[QB][l] ? (QB'(1) << (DATA_W - 1)) : ((QB'(1) << (DATA_W - 1)) - 1'b1);
            w_sat[l] = r_ovf[QB][l] || (r_q[QB][l] > v_lim);
            v_mag    = w_sat[l] ? v_lim[DATA_W-1:0] : r_q[QB][l][DATA_W-1:0];
            w_res[l] = r_neg[QB][l] ? -v_mag : v_mag;
        end
        if (r_dz[QB]) begin
            w_new = '{col_index: '0, row_index: '0, depth_zero: 1'b1, saturated: 1'b0};
        end else begin
            w_new = '{col_index: w_res[0], row_index: w_res[1], depth_zero: 1'b0,
                      saturated: w_sat[0] || w_sat[1]};
        end
    end

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_take) begin
                r_out    <= r_skid;
                r_skid_v <= 1'b0;
            end
        end else if (r_v[NSTG-1]) begin
            if (!r_out_v || w_take) begin
                r_out   <= w_new;
                r_out_v <= 1'b1;
            end else begin
                r_skid   <= w_new;
                r_skid_v <= 1'b1;
            end
        end else if (w_take) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_res.valid      = r_out_v;
    assign o_res.col_index  = r_out.col_index;
    assign o_res.row_index  = r_out.row_index;
    assign o_res.depth_zero = r_out.depth_zero;
    assign o_res.saturated  = r_out.saturated;

    a_skid_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v) else $error("skid entry without output entry");
    a_dz_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.depth_zero) |->
        (r_out.col_index == '0 && r_out.row_index == '0 && !r_out.saturated))
        else $error("depth zero result not cleared");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !o_res.ready) |=> (r_out_v && $stable(r_out)))
        else $error("stalled result changed");
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !w_take) |=> (r_skid_v && $stable(r_skid)))
        else $error("buffered result lost");
endmodule
